// ===== rtl/scl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package scl_pkg;

    localparam int unsigned MAX_REQUEST = 256;
    localparam int unsigned CNT_W       = 9;
    localparam int unsigned TABLE_LEN   = 83;
    localparam int unsigned TABLE_DEPTH = 128;
    localparam int unsigned TABLE_AW    = $clog2(TABLE_DEPTH);
    localparam int unsigned ENTRY_W     = 16;

    localparam logic [1:0] ACT_SCAN   = 2'd0;
    localparam logic [1:0] ACT_LINE   = 2'd1;
    localparam logic [1:0] ACT_SINGLE = 2'd2;

    localparam logic [6:0] CODE_LSHIFT = 7'd42;
    localparam logic [6:0] CODE_RSHIFT = 7'd54;

    localparam logic [7:0] CH_BS   = 8'h08;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_RET  = 8'h0A;
    localparam logic [7:0] CH_PGUP = 8'h81;
    localparam logic [7:0] CH_PGDN = 8'h82;
    localparam logic [7:0] CH_MASK = 8'h2A;

    typedef logic [ENTRY_W-1:0] t_char_pair;

    // Shifted character in the upper byte, plain character in the lower byte.
    function automatic t_char_pair char_rom(input logic [TABLE_AW-1:0] idx);
        t_char_pair p;
        p = '0;
        unique case (idx)
            7'd2:  p = {"!", "1"};
            7'd3:  p = {"\"", "2"};
            7'd4:  p = {"/", "3"};
            7'd5:  p = {"$", "4"};
            7'd6:  p = {"%", "5"};
            7'd7:  p = {"?", "6"};
            7'd8:  p = {"&", "7"};
            7'd9:  p = {"*", "8"};
            7'd10: p = {"(", "9"};
            7'd11: p = {")", "0"};
            7'd12: p = {"_", "-"};
            7'd13: p = {"+", "="};
            7'd14: p = {CH_BS, CH_BS};
            7'd15: p = {CH_TAB, CH_TAB};
            7'd16: p = {"Q", "q"};
            7'd17: p = {"W", "w"};
            7'd18: p = {"E", "e"};
            7'd19: p = {"R", "r"};
            7'd20: p = {"T", "t"};
            7'd21: p = {"Y", "y"};
            7'd22: p = {"U", "u"};
            7'd23: p = {"I", "i"};
            7'd24: p = {"O", "o"};
            7'd25: p = {"P", "p"};
            7'd28: p = {CH_RET, CH_RET};
            7'd30: p = {"A", "a"};
            7'd31: p = {"S", "s"};
            7'd32: p = {"D", "d"};
            7'd33: p = {"F", "f"};
            7'd34: p = {"G", "g"};
            7'd35: p = {"H", "h"};
            7'd36: p = {"J", "j"};
            7'd37: p = {"K", "k"};
            7'd38: p = {"L", "l"};
            7'd39: p = {":", ";"};
            7'd43: p = {">", "<"};
            7'd44: p = {"Z", "z"};
            7'd45: p = {"X", "x"};
            7'd46: p = {"C", "c"};
            7'd47: p = {"V", "v"};
            7'd48: p = {"B", "b"};
            7'd49: p = {"N", "n"};
            7'd50: p = {"M", "m"};
            7'd51: p = {"'", ","};
            7'd52: p = {".", "."};
            7'd53: p = {" ", " "};
            7'd57: p = {" ", " "};
            7'd58: p = {" ", " "};
            7'd73: p = {CH_PGUP, CH_PGUP};
            7'd81: p = {CH_PGDN, CH_PGDN};
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/scl_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scl_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/scancode_line_input_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Keyboard line input from set 1 scancodes.
// Slave stream: one request per scancode byte or per read start; tuser holds
// the action (scancode, start line read, start single-character read).
// Master stream: exactly one result per accepted request, carrying a buffer
// write, request completion (tlast with the final count) and a console echo.
// Configuration: i_cfg_we writes display_enable (index 0) or mask_echo (index 1) at
// the clock edge; the user must write only while no request is in flight (unchecked).
// Pipeline: the accepting edge registers the request and clocks the registered
// read of the character table memory; once the output register is free or
// drains, a later edge loads the state update into the output register.
// Throughput: one request per cycle while m_tready is high; the state update is a
// register loop behind the table read.
// Reset: the character table memory is loaded by a sweep over all 128 entries
// (one entry per cycle) during which s_tready stays low.
// Stall: while m_tready is low the result is held; one more request still
// advances into the table stage, then s_tready drops until the output drains.
module scancode_line_input_core
    import scl_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // scancode[7:0], request_size[16:8], zero pad
    input  wire logic [1:0]  s_tuser,   // action[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,   // write_valid[0], write_index[8:1],
                                        // write_data[16:9], done_count[25:17],
                                        // echo_valid[26], echo_char[34:27], zero pad
    output logic             m_tlast,   // request_done
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic        i_cfg_data
);

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_LINE   = 2'd1,
        MODE_SINGLE = 2'd2
    } t_mode;

    logic [TABLE_AW:0]    r_init_cnt;
    logic                 w_init_done;
    t_char_pair           w_rd_pair;
    logic [TABLE_AW-1:0]  w_rd_addr;

    logic                 r_s1_valid;
    logic [1:0]           r_s1_action;
    logic [7:0]           r_s1_scan;
    logic [CNT_W-1:0]     r_s1_size;

    logic                 r_display_en;
    logic                 r_mask_echo;
    logic [1:0]           r_shift;
    logic [1:0]           n_shift;
    t_mode                r_mode;
    t_mode                n_mode;
    logic [CNT_W-1:0]     r_fill;
    logic [CNT_W-1:0]     n_fill;
    logic [CNT_W-1:0]     r_limit;
    logic [CNT_W-1:0]     n_limit;

    logic                 r_out_valid;
    logic                 r_wr_valid;
    logic                 n_wr_valid;
    logic [7:0]           r_wr_index;
    logic [7:0]           n_wr_index;
    logic [7:0]           r_wr_data;
    logic [7:0]           n_wr_data;
    logic                 r_done;
    logic                 n_done;
    logic [CNT_W-1:0]     r_done_cnt;
    logic [CNT_W-1:0]     n_done_cnt;
    logic                 r_echo_valid;
    logic                 n_echo_valid;
    logic [7:0]           r_echo_char;
    logic [7:0]           n_echo_char;

    logic                 w_s1_move;
    logic                 w_accept;
    logic [6:0]           w_code;
    logic [7:0]           w_ch;
    logic                 w_char_ok;

    assign w_init_done = r_init_cnt[TABLE_AW];
    assign w_s1_move   = r_s1_valid && (!r_out_valid || m_tready);
    assign s_tready    = w_init_done && (!r_s1_valid || w_s1_move);
    assign w_accept    = s_tvalid && s_tready;
    // Hold the table read on the waiting request while it cannot advance.
    assign w_rd_addr   = w_accept ? s_tdata[6:0] : r_s1_scan[6:0];

    scl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_char_ram (
        .i_clk   (i_clk),
        .i_we    (!w_init_done),
        .i_waddr (r_init_cnt[TABLE_AW-1:0]),
        .i_wdata (char_rom(r_init_cnt[TABLE_AW-1:0])),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_pair)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_cnt <= '0;
        end else if (!w_init_done) begin
            r_init_cnt <= r_init_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
        if (w_accept) begin
            r_s1_action <= s_tuser;
            r_s1_scan   <= s_tdata[7:0];
            r_s1_size   <= s_tdata[16:8];
        end
    end

    always_comb begin
        w_code    = r_s1_scan[6:0];
        w_ch      = (r_shift != 2'b00) ? w_rd_pair[15:8] : w_rd_pair[7:0];
        w_char_ok = 1'b0;

        n_shift      = r_shift;
        n_mode       = r_mode;
        n_fill       = r_fill;
        n_limit      = r_limit;
        n_wr_valid   = 1'b0;
        n_wr_index   = '0;
        n_wr_data    = '0;
        n_done       = 1'b0;
        n_done_cnt   = '0;
        n_echo_valid = 1'b0;
        n_echo_char  = '0;

        unique case (r_s1_action)
            ACT_SCAN: begin
                if (r_s1_scan != 8'd0 && w_code < 7'(TABLE_LEN)) begin
                    if (r_s1_scan[7]) begin
                        if (w_code == CODE_LSHIFT) begin
                            n_shift[0] = 1'b0;
                        end else if (w_code == CODE_RSHIFT) begin
                            n_shift[1] = 1'b0;
                        end
                    end else if (w_code == CODE_LSHIFT) begin
                        n_shift[0] = 1'b1;
                    end else if (w_code == CODE_RSHIFT) begin
                        n_shift[1] = 1'b1;
                    end else if (w_rd_pair != '0) begin
                        w_char_ok = 1'b1;
                    end
                end
            end
            ACT_LINE: begin
                if (r_mode == MODE_IDLE && r_s1_size != '0) begin
                    n_mode  = MODE_LINE;
                    n_fill  = '0;
                    n_limit = (r_s1_size > CNT_W'(MAX_REQUEST)) ? CNT_W'(MAX_REQUEST)
                                                                 : r_s1_size;
                end
            end
            ACT_SINGLE: begin
                if (r_mode == MODE_IDLE) begin
                    n_mode  = MODE_SINGLE;
                    n_fill  = '0;
                    n_limit = CNT_W'(1);
                end
            end
            default: begin
            end
        endcase

        if (w_char_ok) begin
            unique case (r_mode)
                MODE_LINE: begin
                    if (w_ch == CH_RET) begin
                        n_done     = 1'b1;
                        n_done_cnt = r_fill;
                        if (r_fill < r_limit) begin
                            n_wr_valid = 1'b1;
                            n_wr_index = r_fill[7:0];
                            n_wr_data  = w_ch;
                            n_done_cnt = r_fill + 1'b1;
                        end
                        n_mode  = MODE_IDLE;
                        n_fill  = '0;
                        n_limit = '0;
                    end else if (w_ch == CH_BS) begin
                        n_fill     = (r_fill != '0) ? r_fill - 1'b1 : r_fill;
                        n_wr_valid = 1'b1;
                        n_wr_index = n_fill[7:0];
                    end else if (r_fill < r_limit) begin
                        n_wr_valid = 1'b1;
                        n_wr_index = r_fill[7:0];
                        n_wr_data  = w_ch;
                        n_fill     = r_fill + 1'b1;
                    end
                end
                MODE_SINGLE: begin
                    n_done     = 1'b1;
                    n_done_cnt = r_fill;
                    if (r_fill < r_limit) begin
                        n_wr_valid = 1'b1;
                        n_wr_index = r_fill[7:0];
                        n_wr_data  = w_ch;
                        n_done_cnt = r_fill + 1'b1;
                    end
                    n_mode  = MODE_IDLE;
                    n_fill  = '0;
                    n_limit = '0;
                end
                default: begin
                end
            endcase

            if (r_display_en) begin
                n_echo_valid = 1'b1;
                n_echo_char  = (r_mask_echo && w_ch != CH_RET && w_ch != CH_BS) ? CH_MASK
                                                                                : w_ch;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_en <= 1'b1;
            r_mask_echo  <= 1'b0;
            r_shift      <= '0;
            r_mode       <= MODE_IDLE;
            r_fill       <= '0;
            r_limit      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx) begin
                    r_mask_echo <= i_cfg_data;
                end else begin
                    r_display_en <= i_cfg_data;
                end
            end
            if (w_s1_move) begin
                r_shift     <= n_shift;
                r_mode      <= n_mode;
                r_fill      <= n_fill;
                r_limit     <= n_limit;
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_wr_valid   <= n_wr_valid;
            r_wr_index   <= n_wr_index;
            r_wr_data    <= n_wr_data;
            r_done       <= n_done;
            r_done_cnt   <= n_done_cnt;
            r_echo_valid <= n_echo_valid;
            r_echo_char  <= n_echo_char;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tlast  = r_done;
    assign m_tdata  = {5'd0, r_echo_char, r_echo_valid, r_done_cnt,
                       r_wr_data, r_wr_index, r_wr_valid};

endmodule

`default_nettype wire
